// ===== src/fsa_pkg.sv =====
// Shared constants, types and helpers of the first-fit slot allocator.
package fsa_pkg;

  localparam int SLOTS      = 16;
  localparam int SLOT_W     = $clog2(SLOTS);
  // Span entries: the pool start twice, then a start and an end for each slot.
  localparam int ELEMS      = 2 * SLOTS + 2;
  localparam int ELEM_W     = $clog2(ELEMS);
  localparam int DATA_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int OUT_SLOT_W = 4;

  localparam logic [DATA_W-1:0] HDR_OVERHEAD = 32'd12;
  localparam logic [DATA_W-1:0] HDR_BYTES    = 32'd8;
  localparam logic [DATA_W-1:0] ALIGN_MASK   = 32'h0000_0003;
  localparam logic [DATA_W-1:0] ALIGN_KEEP   = 32'hFFFF_FFFC;
  localparam logic [DATA_W-1:0] ALIGN_STEP   = 32'd4;
  localparam logic [DATA_W-1:0] SAT_MAX      = 32'hFFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 2'd1;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREE,
    ST_INIT,
    ST_CAND,
    ST_SCAN,
    ST_EVAL,
    ST_FINISH
  } state_t;

  // Slot that holds a span entry; only meaningful for entries two and up.
  function automatic logic [SLOT_W-1:0] elem_slot(input logic [ELEM_W-1:0] e);
    logic [ELEM_W-2:0] tmp;
    tmp = e[ELEM_W-1:1] - 1'b1;
    return tmp[SLOT_W-1:0];
  endfunction

  // Span entries zero and one are the pool start.
  function automatic logic elem_is_base(input logic [ELEM_W-1:0] e);
    return (e[ELEM_W-1:1] == '0);
  endfunction

endpackage

// ===== src/first_fit_slot_allocator.sv =====
// Top level of the first-fit slot allocator: slot table, sequencer and datapath.
//
// Usage. The block tracks up to SLOTS objects inside a byte pool given by the
// base_addr and pool_size registers, written through cfg_we, cfg_index and
// cfg_wdata. Writing either register empties the slot table and sets the free
// byte count to the current pool size. Write configuration only while busy is
// low. An item is accepted at a rising edge where start is high and busy is
// low; busy then stays high until the result has been computed. Every item
// gives exactly one result, shown on the out_ ports for a single cycle with
// out_valid high. The receiver cannot stall, so the result must be taken in
// that cycle.
// Sequencing. A free request, and an allocate that fails on the free byte
// count or on a full table, is settled in a single state (ST_FREE or ST_INIT)
// that registers the result as it returns to idle. A fitting allocate ranks
// every span entry (the pool start twice, plus the start and end of each
// occupied slot) by scanning all entries with one shared compare unit: each
// entry passes through ST_CAND, and an entry in use is then compared with
// every entry in ST_SCAN and its gap judged in ST_EVAL; ST_INIT and ST_FINISH
// add setup and write-back. The entry-by-entry scan dominates the busy time.
// Throughput. Busy is low in the cycle of the strobe, so the next item can be
// accepted at the edge that ends it.
// Reset. rst_n clears the control registers, empties the table and zeroes the free
// byte count; no clearing pass is needed because each slot has valid bits.
module first_fit_slot_allocator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [fsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fsa_pkg::DATA_W-1:0]       cfg_wdata,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_req_type,
  input  logic [fsa_pkg::DATA_W-1:0]       in_obj_size,
  input  logic [fsa_pkg::DATA_W-1:0]       in_obj_addr,
  input  logic [fsa_pkg::DATA_W-1:0]       in_header_index,
  output logic                             out_valid,
  output logic                             out_ok,
  output logic [fsa_pkg::DATA_W-1:0]       out_result_addr,
  output logic [fsa_pkg::OUT_SLOT_W-1:0]   out_slot_index,
  output logic [fsa_pkg::DATA_W-1:0]       out_free_bytes
);
  import fsa_pkg::*;

  // Sequencer state.
  state_t state_r, state_nxt;

  // Configuration and bookkeeping.
  logic [DATA_W-1:0] base_r, base_nxt;
  logic [DATA_W-1:0] pool_r, pool_nxt;
  logic [DATA_W-1:0] end_r, end_nxt;
  logic [DATA_W-1:0] bytes_free_r, bytes_free_nxt;

  // Slot table. Address and length are plain storage; written_r marks an entry
  // that holds an address, used_r one whose length is nonzero.
  logic [DATA_W-1:0] slot_addr_r [SLOTS];
  logic [DATA_W-1:0] slot_len_r  [SLOTS];
  logic [SLOTS-1:0]  written_r, written_nxt;
  logic [SLOTS-1:0]  used_r, used_nxt;
  logic              tbl_we;
  logic [SLOT_W-1:0] tbl_wslot;
  logic [DATA_W-1:0] tbl_waddr;
  logic [DATA_W-1:0] tbl_wlen;

  // Captured request.
  logic [DATA_W-1:0] size_r, size_nxt;
  logic [DATA_W-1:0] addr_r, addr_nxt;
  logic [DATA_W-1:0] hidx_r, hidx_nxt;

  // Ranking loop state.
  logic [ELEM_W-1:0] e_r, e_nxt;
  logic [ELEM_W-1:0] f_r, f_nxt;
  logic [DATA_W-1:0] ve_r, ve_nxt;
  logic [ELEM_W-1:0] rank_r, rank_nxt;
  logic [DATA_W-1:0] succ_r, succ_nxt;
  logic              succ_found_r, succ_found_nxt;
  logic              best_found_r, best_found_nxt;
  logic [ELEM_W-1:0] best_rank_r, best_rank_nxt;
  logic [DATA_W-1:0] best_start_r, best_start_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;

  // Result registers.
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ok_r, out_ok_nxt;
  logic [DATA_W-1:0]     out_addr_r, out_addr_nxt;
  logic [OUT_SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [DATA_W-1:0]     out_free_r, out_free_nxt;

  // Shared read port of the slot table and the span entry it yields.
  logic [ELEM_W-1:0] sel_e;
  logic [SLOT_W-1:0] rd_slot;
  logic [DATA_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_len;
  logic              rd_used;
  logic [DATA_W-1:0] elem_val;
  logic              elem_valid;

  // Status for the sequencer.
  logic              accept;
  logic              no_room;
  logic              have_empty;
  logic [SLOT_W-1:0] empty_slot;
  logic              cand_valid;
  logic              scan_last;
  logic              cand_last;

  // Wide temporaries.
  logic [DATA_W:0]   need;
  logic [DATA_W-1:0] gap_end;
  logic [DATA_W:0]   gap;
  logic              fits;
  logic              f_before;
  logic [DATA_W-1:0] aligned;
  logic [DATA_W:0]   free_sum;
  logic              free_ok;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign need     = {1'b0, size_r} + {1'b0, HDR_OVERHEAD};
  assign no_room  = (need > {1'b0, bytes_free_r});
  assign scan_last = (f_r == ELEM_W'(ELEMS - 1));
  assign cand_last = (e_r == ELEM_W'(ELEMS - 1));
  assign cand_valid = elem_valid;

  // Lowest slot whose length is zero.
  always_comb begin
    have_empty = 1'b0;
    empty_slot = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!used_r[s]) begin
        have_empty = 1'b1;
        empty_slot = SLOT_W'(s);
      end
    end
  end

  // One table read per cycle; the state picks which entry is looked at.
  always_comb begin
    sel_e = (state_r == ST_SCAN) ? f_r : e_r;
    if (state_r == ST_FREE) begin
      rd_slot = hidx_r[SLOT_W-1:0];
    end else begin
      rd_slot = elem_slot(sel_e);
    end
    rd_addr = written_r[rd_slot] ? slot_addr_r[rd_slot] : '0;
    rd_len  = written_r[rd_slot] ? slot_len_r[rd_slot]  : '0;
    rd_used = used_r[rd_slot];
    if (elem_is_base(sel_e)) begin
      elem_val   = base_r;
      elem_valid = 1'b1;
    end else begin
      elem_val   = sel_e[0] ? (rd_addr + rd_len) : (rd_addr - HDR_BYTES);
      elem_valid = rd_used;
    end
  end

  // Gap behind the candidate entry: up to its successor, or to the pool end
  // when the candidate is the highest entry.
  always_comb begin
    gap_end = succ_found_r ? succ_r : end_r;
    gap     = (gap_end >= ve_r) ? {1'b0, gap_end - ve_r} : '0;
    fits    = rank_r[0] && (gap >= need);
  end

  assign f_before = (elem_val < ve_r) || ((elem_val == ve_r) && (f_r < e_r));

  always_comb begin
    if ((best_start_r & ALIGN_MASK) != '0) begin
      aligned = (best_start_r + ALIGN_STEP) & ALIGN_KEEP;
    end else begin
      aligned = best_start_r;
    end
  end

  assign free_ok  = (addr_r != '0) && (hidx_r < DATA_W'(SLOTS)) && (rd_addr == addr_r);
  assign free_sum = {1'b0, bytes_free_r} + {1'b0, rd_len} + {1'b0, HDR_OVERHEAD};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_req_type == REQ_FREE) ? ST_FREE : ST_INIT;
        end
      end
      ST_FREE: begin
        state_nxt = ST_IDLE;
      end
      ST_INIT: begin
        state_nxt = (no_room || !have_empty) ? ST_IDLE : ST_CAND;
      end
      ST_CAND: begin
        if (cand_valid) begin
          state_nxt = ST_SCAN;
        end else if (cand_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = cand_last ? ST_FINISH : ST_CAND;
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    base_nxt       = base_r;
    pool_nxt       = pool_r;
    end_nxt        = end_r;
    bytes_free_nxt = bytes_free_r;
    written_nxt    = written_r;
    used_nxt       = used_r;
    tbl_we         = 1'b0;
    tbl_wslot      = idx_r;
    tbl_waddr      = '0;
    tbl_wlen       = size_r;
    size_nxt       = size_r;
    addr_nxt       = addr_r;
    hidx_nxt       = hidx_r;
    e_nxt          = e_r;
    f_nxt          = f_r;
    ve_nxt         = ve_r;
    rank_nxt       = rank_r;
    succ_nxt       = succ_r;
    succ_found_nxt = succ_found_r;
    best_found_nxt = best_found_r;
    best_rank_nxt  = best_rank_r;
    best_start_nxt = best_start_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = 1'b0;
    out_ok_nxt     = out_ok_r;
    out_addr_nxt   = out_addr_r;
    out_slot_nxt   = out_slot_r;
    out_free_nxt   = out_free_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          size_nxt     = in_obj_size;
          addr_nxt     = in_obj_addr;
          hidx_nxt     = in_header_index;
        end
        if (cfg_we) begin
          case (cfg_index)
            CFG_BASE_ADDR: begin
              base_nxt       = cfg_wdata;
              bytes_free_nxt = pool_r;
              written_nxt    = '0;
              used_nxt       = '0;
            end
            CFG_POOL_SIZE: begin
              pool_nxt       = cfg_wdata;
              bytes_free_nxt = cfg_wdata;
              written_nxt    = '0;
              used_nxt       = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FREE: begin
        out_valid_nxt = 1'b1;
        out_addr_nxt  = '0;
        out_slot_nxt  = '0;
        out_ok_nxt    = free_ok;
        if (free_ok) begin
          bytes_free_nxt       = free_sum[DATA_W] ? SAT_MAX : free_sum[DATA_W-1:0];
          written_nxt[rd_slot] = 1'b0;
          used_nxt[rd_slot]    = 1'b0;
          out_free_nxt         = free_sum[DATA_W] ? SAT_MAX : free_sum[DATA_W-1:0];
        end else begin
          out_free_nxt = bytes_free_r;
        end
      end
      ST_INIT: begin
        idx_nxt        = empty_slot;
        end_nxt        = base_r + pool_r;
        e_nxt          = '0;
        best_found_nxt = 1'b0;
        if (no_room || !have_empty) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b0;
          out_addr_nxt  = '0;
          out_slot_nxt  = '0;
          out_free_nxt  = bytes_free_r;
        end
      end
      ST_CAND: begin
        ve_nxt         = elem_val;
        rank_nxt       = '0;
        succ_found_nxt = 1'b0;
        f_nxt          = '0;
        if (!cand_valid && !cand_last) begin
          e_nxt = e_r + 1'b1;
        end
      end
      ST_SCAN: begin
        if (elem_valid && (f_r != e_r)) begin
          if (f_before) begin
            rank_nxt = rank_r + 1'b1;
          end else if (!succ_found_r || (elem_val < succ_r)) begin
            succ_nxt       = elem_val;
            succ_found_nxt = 1'b1;
          end
        end
        f_nxt = f_r + 1'b1;
      end
      ST_EVAL: begin
        if (fits && (!best_found_r || (rank_r < best_rank_r))) begin
          best_found_nxt = 1'b1;
          best_rank_nxt  = rank_r;
          best_start_nxt = ve_r;
        end
        if (!cand_last) begin
          e_nxt = e_r + 1'b1;
        end
      end
      ST_FINISH: begin
        out_valid_nxt = 1'b1;
        if (best_found_r) begin
          tbl_we              = 1'b1;
          tbl_waddr           = aligned + HDR_BYTES;
          written_nxt[idx_r]  = 1'b1;
          used_nxt[idx_r]     = (size_r != '0);
          bytes_free_nxt      = bytes_free_r - size_r - HDR_OVERHEAD;
          out_ok_nxt          = 1'b1;
          out_addr_nxt        = aligned + HDR_BYTES;
          out_slot_nxt        = OUT_SLOT_W'(idx_r);
          out_free_nxt        = bytes_free_r - size_r - HDR_OVERHEAD;
        end else begin
          out_ok_nxt   = 1'b0;
          out_addr_nxt = '0;
          out_slot_nxt = '0;
          out_free_nxt = bytes_free_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      base_r       <= '0;
      pool_r       <= '0;
      bytes_free_r <= '0;
      written_r    <= '0;
      used_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      base_r       <= base_nxt;
      pool_r       <= pool_nxt;
      bytes_free_r <= bytes_free_nxt;
      written_r    <= written_nxt;
      used_r       <= used_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    end_r        <= end_nxt;
    size_r       <= size_nxt;
    addr_r       <= addr_nxt;
    hidx_r       <= hidx_nxt;
    e_r          <= e_nxt;
    f_r          <= f_nxt;
    ve_r         <= ve_nxt;
    rank_r       <= rank_nxt;
    succ_r       <= succ_nxt;
    succ_found_r <= succ_found_nxt;
    best_found_r <= best_found_nxt;
    best_rank_r  <= best_rank_nxt;
    best_start_r <= best_start_nxt;
    idx_r        <= idx_nxt;
    out_ok_r     <= out_ok_nxt;
    out_addr_r   <= out_addr_nxt;
    out_slot_r   <= out_slot_nxt;
    out_free_r   <= out_free_nxt;
  end

  // Slot table storage.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      slot_addr_r[tbl_wslot] <= tbl_waddr;
      slot_len_r[tbl_wslot]  <= tbl_wlen;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_result_addr = out_addr_r;
  assign out_slot_index  = out_slot_r;
  assign out_free_bytes  = out_free_r;

  // A result is strobed only once the sequencer has gone back to idle.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe while the sequencer is still working");

  // A failed request never reports an address or a slot.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> ((out_addr_r == '0) && (out_slot_r == '0)))
    else $error("failed request reports an address or slot");

  // A slot with a nonzero length always holds an address.
  a_used_written: assert property (@(posedge clk) disable iff (!rst_n)
    ((used_r & ~written_r) == '0))
    else $error("slot marked in use without an address");

  // The rank of a candidate never exceeds the number of entries scanned.
  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (rank_r <= f_r))
    else $error("candidate rank outruns the scan");

  // A successful allocate leaves its slot written in the next cycle.
  a_alloc_write: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FINISH) && best_found_r) |=> written_r[$past(idx_r)])
    else $error("allocated slot not recorded");

endmodule
